[rtl/abrf_pkg.sv]
// Shared constants and types of the audio burst ring FIFO.
package abrf_pkg;

  // Default sizes of the ring and of the longest read request.
  localparam int unsigned ABRF_RING_BYTES = 65536;
  localparam int unsigned ABRF_MAX_READ   = 64;

  // Fixed width of the count, threshold and fill level fields.
  localparam int unsigned FIELD_W = 17;

  // Threshold value after reset.
  localparam logic [FIELD_W-1:0] THRESH_RESET = 17'd32768;

  // Input item actions.
  localparam logic [1:0] ACT_HDR  = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Result item kinds.
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_RDATA = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

endpackage

[rtl/audio_burst_ring_fifo.sv]
// Top level of the audio burst ring FIFO.
//
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid_i/ready_o    cfg_data_i (start threshold)
// in       in         in_valid_i/in_stall_o  action_i, count_i, data_byte_i
// out      out        out_valid_o/stall_i    kind_o, accepted_o, fill_level_o, out_byte_o,
//                                            silence_o, last_o, started_o
//
// A read request emits one result item per byte; when served, the first
// byte waits for the single, registered read port of the ring memory.
// Reset clears the pointers, flags and burst state; the ring memory is not
// cleared, as only bytes written since are ever read. An output stall pauses
// the read sequence and, once the output register is full, the input too.
module audio_burst_ring_fifo import abrf_pkg::*; #(
  parameter int unsigned RING_BYTES = ABRF_RING_BYTES,
  parameter int unsigned MAX_READ   = ABRF_MAX_READ
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [FIELD_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [FIELD_W-1:0] count_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic               accepted_o,
  output logic [FIELD_W-1:0] fill_level_o,
  output logic [7:0]         out_byte_o,
  output logic               silence_o,
  output logic               last_o,
  output logic               started_o
);

  localparam int unsigned AW = $clog2(RING_BYTES);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Sequencing and pointer logic.
  abrf_ctrl #(
    .RING_BYTES(RING_BYTES),
    .MAX_READ  (MAX_READ)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .count_i     (count_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .accepted_o  (accepted_o),
    .fill_level_o(fill_level_o),
    .out_byte_o  (out_byte_o),
    .silence_o   (silence_o),
    .last_o      (last_o),
    .started_o   (started_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Ring byte store.
  abrf_ring_mem #(
    .RING_BYTES(RING_BYTES)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_we),
    .wr_addr_i(mem_waddr),
    .wr_data_i(mem_wdata),
    .rd_en_i  (mem_re),
    .rd_addr_i(mem_raddr),
    .rd_data_o(mem_rdata)
  );

endmodule

[rtl/abrf_ring_mem.sv]
// Byte store of the ring: one write port and one registered read port.
module abrf_ring_mem import abrf_pkg::*; #(
  parameter int unsigned RING_BYTES = ABRF_RING_BYTES,
  localparam int unsigned AW = $clog2(RING_BYTES)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [RING_BYTES];
  logic [7:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/abrf_ctrl.sv]
// Pointer, burst and read sequencing logic with the output register.
module abrf_ctrl import abrf_pkg::*; #(
  parameter int unsigned RING_BYTES = ABRF_RING_BYTES,
  parameter int unsigned MAX_READ   = ABRF_MAX_READ,
  localparam int unsigned AW = $clog2(RING_BYTES),
  localparam int unsigned PW = AW + 1,
  localparam int unsigned NW = $clog2(MAX_READ + 1),
  localparam int unsigned CW = ((PW > FIELD_W) ? PW : FIELD_W) + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [FIELD_W-1:0] cfg_data_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [FIELD_W-1:0] count_i,
  input  logic [7:0]         data_byte_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic               accepted_o,
  output logic [FIELD_W-1:0] fill_level_o,
  output logic [7:0]         out_byte_o,
  output logic               silence_o,
  output logic               last_o,
  output logic               started_o,
  // Ring memory
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output logic [7:0]         mem_wdata_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  logic [7:0]         mem_rdata_i
);

  state_e             state_q, state_d;
  logic [PW-1:0]      wp_q, wp_d;
  logic [PW-1:0]      rp_q, rp_d;
  logic               started_q, started_d;
  logic [FIELD_W-1:0] burst_rem_q, burst_rem_d;
  logic               burst_ok_q, burst_ok_d;
  logic [FIELD_W-1:0] thresh_q;
  logic [NW-1:0]      n_q, n_d;
  logic [NW-1:0]      iss_q, iss_d;
  logic [NW-1:0]      emit_q, emit_d;
  logic               serve_q, serve_d;
  logic [FIELD_W-1:0] fill_out_q, fill_out_d;
  logic [AW-1:0]      rd_addr_q, rd_addr_d;
  logic               rd_pend_q, rd_pend_d;

  logic               out_valid_q;
  logic               kind_q, accepted_q, silence_q, last_q, ostart_q;
  logic [FIELD_W-1:0] ofill_q;
  logic [7:0]         obyte_q;

  logic               out_load;
  logic               kind_d, accepted_d, silence_d, last_d, ostart_d;
  logic [FIELD_W-1:0] ofill_d;
  logic [7:0]         obyte_d;

  logic [PW-1:0]      fill;
  logic [CW-1:0]      fill_ext, free_ext, count_ext, thr_ext, after_ext;
  logic [NW-1:0]      sat_n;
  logic               rd_fits, fits_burst;
  logic               out_free, in_acc, emit, issue, emit_last;

  // Fill level and the comparisons made at acceptance.
  assign fill       = wp_q - rp_q;
  assign fill_ext   = CW'(fill);
  assign free_ext   = CW'(RING_BYTES) - fill_ext;
  assign count_ext  = CW'(count_i);
  assign thr_ext    = CW'(thresh_q);
  assign fits_burst = count_ext <= free_ext;
  assign sat_n      = (count_i > FIELD_W'(MAX_READ)) ? NW'(MAX_READ) : count_i[NW-1:0];
  assign rd_fits    = CW'(sat_n) <= fill_ext;
  assign after_ext  = fill_ext - CW'(sat_n);

  // Handshakes.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Read sequencing: one memory read and one emitted byte per cycle at most.
  assign emit      = (state_q == ST_READ) && (serve_q ? (rd_pend_q && out_free) : out_free);
  assign issue     = (state_q == ST_READ) && serve_q && (iss_q != n_q) && (!rd_pend_q || emit);
  assign emit_last = (emit_q + 1'b1) == n_q;

  // Next-state logic for items and for the read sequence.
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    started_d   = started_q;
    burst_rem_d = burst_rem_q;
    burst_ok_d  = burst_ok_q;
    n_d         = n_q;
    iss_d       = iss_q;
    emit_d      = emit_q;
    serve_d     = serve_q;
    fill_out_d  = fill_out_q;
    rd_addr_d   = rd_addr_q;
    rd_pend_d   = rd_pend_q;
    mem_we_o    = 1'b0;
    out_load    = 1'b0;
    kind_d      = KIND_ACK;
    accepted_d  = 1'b0;
    ofill_d     = fill_ext[FIELD_W-1:0];
    obyte_d     = 8'd0;
    silence_d   = 1'b0;
    last_d      = 1'b1;
    ostart_d    = started_q;

    if (in_acc) begin
      unique case (action_i)
        ACT_HDR: begin
          burst_ok_d  = fits_burst;
          burst_rem_d = count_i;
          if (fill_ext >= thr_ext) begin
            started_d = 1'b1;
          end
          out_load   = 1'b1;
          accepted_d = fits_burst;
          ostart_d   = started_d;
        end
        ACT_DATA: begin
          if (burst_rem_q != '0) begin
            burst_rem_d = burst_rem_q - 1'b1;
            if (burst_ok_q) begin
              mem_we_o = 1'b1;
              wp_d     = wp_q + 1'b1;
            end
          end
        end
        ACT_READ: begin
          if (sat_n != '0) begin
            state_d   = ST_READ;
            n_d       = sat_n;
            iss_d     = '0;
            emit_d    = '0;
            serve_d   = rd_fits;
            rd_addr_d = rp_q[AW-1:0];
            rd_pend_d = 1'b0;
            if (rd_fits) begin
              rp_d       = rp_q + PW'(sat_n);
              fill_out_d = after_ext[FIELD_W-1:0];
            end else begin
              fill_out_d = fill_ext[FIELD_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (issue) begin
      rd_addr_d = rd_addr_q + 1'b1;
      iss_d     = iss_q + 1'b1;
    end
    if (state_q == ST_READ) begin
      rd_pend_d = issue ? 1'b1 : (emit ? 1'b0 : rd_pend_q);
    end

    if (emit) begin
      out_load   = 1'b1;
      kind_d     = KIND_RDATA;
      accepted_d = serve_q;
      ofill_d    = fill_out_q;
      obyte_d    = serve_q ? mem_rdata_i : 8'd0;
      silence_d  = !serve_q;
      last_d     = emit_last;
      emit_d     = emit_q + 1'b1;
      if (emit_last) begin
        state_d = ST_IDLE;
      end
    end
  end

  assign mem_waddr_o = wp_q[AW-1:0];
  assign mem_wdata_o = data_byte_i;
  assign mem_re_o    = issue;
  assign mem_raddr_o = rd_addr_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      started_q   <= 1'b0;
      burst_rem_q <= '0;
      burst_ok_q  <= 1'b0;
      thresh_q    <= THRESH_RESET;
      n_q         <= '0;
      iss_q       <= '0;
      emit_q      <= '0;
      serve_q     <= 1'b0;
      rd_addr_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      started_q   <= started_d;
      burst_rem_q <= burst_rem_d;
      burst_ok_q  <= burst_ok_d;
      n_q         <= n_d;
      iss_q       <= iss_d;
      emit_q      <= emit_d;
      serve_q     <= serve_d;
      rd_addr_q   <= rd_addr_d;
      rd_pend_q   <= rd_pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thresh_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload and the fill level held for a read sequence.
  always_ff @(posedge clk_i) begin
    fill_out_q <= fill_out_d;
    if (out_load) begin
      kind_q     <= kind_d;
      accepted_q <= accepted_d;
      ofill_q    <= ofill_d;
      obyte_q    <= obyte_d;
      silence_q  <= silence_d;
      last_q     <= last_d;
      ostart_q   <= ostart_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign accepted_o   = accepted_q;
  assign fill_level_o = ofill_q;
  assign out_byte_o   = obyte_q;
  assign silence_o    = silence_q;
  assign last_o       = last_q;
  assign started_o    = ostart_q;

  // The ring never holds more bytes than it has entries.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(fill) <= CW'(RING_BYTES))
    else $error("fill level exceeds ring size");

  // A pending memory byte exists only within a served read.
  a_pend_served: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ((state_q == ST_READ) && serve_q))
    else $error("pending read byte outside a served read");

  // Issued reads run at most one ahead of emitted bytes.
  a_issue_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_READ) && serve_q) |->
      ((iss_q == emit_q) || (iss_q == emit_q + 1'b1)))
    else $error("read issue and emission out of step");

  // The last byte of a read request ends the sequence.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> (state_q == ST_IDLE))
    else $error("read sequence did not end after its last byte");

endmodule

[sim/audio_burst_ring_fifo_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the audio burst ring FIFO with its own byte ring predictor.
module audio_burst_ring_fifo_test;
  import abrf_pkg::*;

  // Action code that the block has no use for.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Address bits of the predicted ring.
  localparam int RING_AW = $clog2(ABRF_RING_BYTES);
  // Cycles left to the block after the last reply, before a register write or the end.
  localparam int SETTLE_CYCLES = 16;
  // Far above the slowest correct run, with every gap and stall at its longest.
  localparam int CYCLE_LIMIT = 2_000_000;
  // Mismatch reports stop here so that a broken block does not flood the log.
  localparam int REPORT_CAP = 50;

  // One result item as the block should present it.
  typedef struct {
    logic               kind;
    logic               accepted;
    logic [FIELD_W-1:0] fill;
    logic [7:0]         out_byte;
    logic               silence;
    logic               last;
    logic               started;
  } reply_t;

  // Tracks ring contents, pointers and flags, and holds the replies still owed.
  class ring_fill_tracker;
    logic [7:0]         ring_mem [ABRF_RING_BYTES];
    logic [FIELD_W-1:0] wr_ptr;
    logic [FIELD_W-1:0] rd_ptr;
    logic [FIELD_W-1:0] burst_left;
    logic [FIELD_W-1:0] threshold;
    logic               started;
    logic               burst_fits;
    reply_t             pending_replies [$];
    int                 mismatches;

    function new();
      wr_ptr      = '0;
      rd_ptr      = '0;
      burst_left  = '0;
      threshold   = THRESH_RESET;
      started     = 1'b0;
      burst_fits  = 1'b0;
      mismatches  = 0;
    endfunction

    // Pointers run modulo twice the ring size, which is the 17-bit wrap.
    function logic [FIELD_W-1:0] fill();
      return wr_ptr - rd_ptr;
    endfunction

    function void owe(logic kind, logic acc, logic [FIELD_W-1:0] level, logic [7:0] b,
                      logic sil, logic last);
      reply_t r;
      r.kind     = kind;
      r.accepted = acc;
      r.fill     = level;
      r.out_byte = b;
      r.silence  = sil;
      r.last     = last;
      r.started  = started;
      pending_replies.push_back(r);
    endfunction

    // Advances the predicted state by one accepted input item.
    function void take_item(logic [1:0] act, logic [FIELD_W-1:0] cnt, logic [7:0] dat);
      logic [FIELD_W-1:0] level;
      int unsigned        n;
      level = fill();
      case (act)
        ACT_HDR: begin
          burst_fits = (cnt <= (ABRF_RING_BYTES - level));
          burst_left = cnt;
          if (level >= threshold) started = 1'b1;
          owe(KIND_ACK, burst_fits, level, 8'h00, 1'b0, 1'b1);
        end
        ACT_DATA: begin
          // A byte outside any burst is dropped without trace.
          if (burst_left != 0) begin
            burst_left = burst_left - 1'b1;
            if (burst_fits) begin
              ring_mem[wr_ptr[RING_AW-1:0]] = dat;
              wr_ptr = wr_ptr + 1'b1;
            end
          end
        end
        ACT_READ: begin
          n = (cnt > ABRF_MAX_READ) ? ABRF_MAX_READ : cnt;
          if (n != 0 && n <= level) begin
            for (int i = 0; i < n; i++)
              owe(KIND_RDATA, 1'b1, level - FIELD_W'(n),
                  ring_mem[RING_AW'(rd_ptr + FIELD_W'(i))], 1'b0, i == n - 1);
            rd_ptr = rd_ptr + FIELD_W'(n);
          end else begin
            // Underrun: zero bytes, pointers stay where they are.
            for (int i = 0; i < n; i++)
              owe(KIND_RDATA, 1'b0, level, 8'h00, 1'b1, i == n - 1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [FIELD_W-1:0] want,
                              logic [FIELD_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("%s: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    // Compares one accepted result item with the oldest reply owed.
    function void match_output(logic kind, logic acc, logic [FIELD_W-1:0] level,
                               logic [7:0] b, logic sil, logic last, logic st);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("result item with no reply owed: kind %0d fill %0d", kind, level);
        return;
      end
      want = pending_replies.pop_front();
      check_field("kind", want.kind, kind);
      check_field("accepted", want.accepted, acc);
      check_field("fill_level", want.fill, level);
      check_field("out_byte", want.out_byte, b);
      check_field("silence", want.silence, sil);
      check_field("last", want.last, last);
      check_field("started", want.started, st);
    endfunction
  endclass

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [FIELD_W-1:0] cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [1:0]         action_i     = ACT_HDR;
  logic [FIELD_W-1:0] count_i      = '0;
  logic [7:0]         data_byte_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic               kind_o;
  logic               accepted_o;
  logic [FIELD_W-1:0] fill_level_o;
  logic [7:0]         out_byte_o;
  logic               silence_o;
  logic               last_o;
  logic               started_o;

  ring_fill_tracker tracker;
  int               cycles      = 0;
  int               stall_left  = 0;
  int               calm_left   = 0;
  int               sender_calm = 0;
  int               gap_odds    = 25;

  audio_burst_ring_fifo DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .count_i      (count_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .accepted_o   (accepted_o),
    .fill_level_o (fill_level_o),
    .out_byte_o   (out_byte_o),
    .silence_o    (silence_o),
    .last_o       (last_o),
    .started_o    (started_o)
  );

  // 10 ns clock.
  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: mostly short stalls, a few long ones, and calm stretches.
  always @(posedge clk_i) begin : out_stall_gen
    int r;
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (calm_left != 0) begin
      calm_left--;
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(99);
      if (r < 2) begin
        calm_left = $urandom_range(300, 80);
        out_stall_i <= 1'b0;
      end else if (r < 4) begin
        stall_left = $urandom_range(23, 7);
        out_stall_i <= 1'b1;
      end else if (r < 18) begin
        stall_left = $urandom_range(2, 0);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Signals are stable around the falling edge, so the handshake is judged there.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0)
      tracker.match_output(kind_o, accepted_o, fill_level_o, out_byte_o, silence_o, last_o,
                           started_o);
  end

  // Idle cycles before the next item: mostly none or a few, now and then a long gap.
  function automatic int pick_gap();
    if (sender_calm != 0) begin
      sender_calm--;
      return 0;
    end
    if ($urandom_range(49) == 0) begin
      sender_calm = $urandom_range(60, 20);
      return 0;
    end
    if ($urandom_range(99) >= gap_odds) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(24, 8);
    return $urandom_range(3, 1);
  endfunction

  // Presents one input item and holds it until the block takes it.
  task automatic send(input logic [1:0] act, input int unsigned cnt,
                      input int unsigned dat);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    count_i     <= FIELD_W'(cnt);
    data_byte_i <= 8'(dat);
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    tracker.take_item(act, FIELD_W'(cnt), 8'(dat));
    @(posedge clk_i);
  endtask

  // Stops sending and waits for every owed reply, then lets the block come to rest.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the start threshold once the block is idle.
  task automatic write_threshold(input int unsigned value);
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= FIELD_W'(value);
    do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
    tracker.threshold = FIELD_W'(value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed bursts and reads with random content, plus some noise.
  task automatic random_traffic(input int goal);
    int          done;
    int          r;
    int          len;
    int          n_bytes;
    int          hi;
    int unsigned cnt;
    done = 0;
    while (done < goal) begin
      r = $urandom_range(99);
      if (r < 3) begin
        // The sender holds off until the block has delivered everything.
        settle_idle();
      end else if (r < 45) begin
        if ($urandom_range(9) == 0)
          len = ($urandom_range(1) == 0) ? ABRF_RING_BYTES : $urandom_range(65535, 100);
        else
          len = $urandom_range(24, 0);
        send(ACT_HDR, len, $urandom);
        done++;
        // Long bursts are cut short; others are sometimes truncated or overrun.
        n_bytes = (len > 32) ? $urandom_range(32, 0) : len;
        case ($urandom_range(7))
          0:       n_bytes = $urandom_range(n_bytes, 0);
          1:       n_bytes = n_bytes + $urandom_range(3, 1);
          default: ;
        endcase
        repeat (n_bytes) begin
          send(ACT_DATA, $urandom_range(65536, 0), $urandom);
          done++;
        end
      end else if (r < 85) begin
        case ($urandom_range(9))
          0:       cnt = 0;
          1:       cnt = ($urandom_range(1) == 0) ? ABRF_RING_BYTES : $urandom_range(65535, 65);
          default: begin
            hi = tracker.fill() + 6;
            if (hi > ABRF_MAX_READ) hi = ABRF_MAX_READ;
            cnt = $urandom_range(hi, 1);
          end
        endcase
        send(ACT_READ, cnt, $urandom);
        if (cnt != 0) done++;
      end else if (r < 95) begin
        send(ACT_DATA, $urandom_range(65536, 0), $urandom);
      end else begin
        send(ACT_UNUSED, $urandom_range(65536, 0), $urandom);
      end
    end
  endtask

  // Main sequence.
  initial begin
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at the reset threshold.
    send(ACT_HDR, 0, 8'h00);
    send(ACT_DATA, 0, 8'hAA);
    send(ACT_READ, 0, 8'h00);
    send(ACT_READ, 5, 8'h00);
    send(ACT_UNUSED, ABRF_RING_BYTES, 8'hFF);
    send(ACT_HDR, 4, 8'h00);
    send(ACT_DATA, 0, 8'h00);
    send(ACT_DATA, ABRF_RING_BYTES, 8'hFF);
    send(ACT_DATA, 0, 8'hA5);
    send(ACT_DATA, 0, 8'h5A);
    send(ACT_READ, 3, 8'h00);
    send(ACT_READ, 70, 8'h00);
    send(ACT_HDR, ABRF_RING_BYTES, 8'h00);
    send(ACT_DATA, 0, 8'h11);
    send(ACT_DATA, 0, 8'h22);
    send(ACT_HDR, 3, 8'h00);
    send(ACT_DATA, 0, 8'h3C);
    send(ACT_DATA, 0, 8'hC3);
    send(ACT_HDR, 2, 8'h00);
    send(ACT_DATA, 0, 8'h81);
    send(ACT_DATA, 0, 8'h7E);
    send(ACT_READ, ABRF_RING_BYTES, 8'h00);
    send(ACT_READ, 5, 8'h00);
    send(ACT_READ, 1, 8'h00);
    send(ACT_HDR, 0, 8'h00);

    // Highest threshold: small fills never raise the flag.
    write_threshold(ABRF_RING_BYTES);
    random_traffic(60);

    // Lowest threshold, then random ones.
    write_threshold(0);
    random_traffic(60);
    write_threshold($urandom_range(65535, 1));
    random_traffic(55);
    write_threshold($urandom_range(65536, 0));
    random_traffic(30);

    settle_idle();
    if (tracker.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
